### design/tqs_pkg.sv
// Package for the thread queue scheduler.
// Holds field widths, default parameter values, request and status codes, the sequencer
// state type and the result record. No dependencies.
package tqs_pkg;

    localparam int unsigned THREAD_COUNT_DEF = 8;
    localparam int unsigned TICK_WIDTH_DEF   = 16;

    localparam int unsigned REQ_W   = 3;
    localparam int unsigned TICKS_W = 16;
    localparam int unsigned CHAR_W  = 8;
    localparam int unsigned STAT_W  = 2;
    localparam int unsigned ID_W    = 3;
    localparam int unsigned CNT_W   = 4;

    typedef enum logic [REQ_W-1:0] {
        REQ_CREATE = 3'd0,
        REQ_SLEEP  = 3'd1,
        REQ_WAIT   = 3'd2,
        REQ_KILL   = 3'd3,
        REQ_SCHED  = 3'd4,
        REQ_TICK   = 3'd5,
        REQ_FEED   = 3'd6
    } t_req;

    typedef enum logic [STAT_W-1:0] {
        ST_OK      = 2'd0,
        ST_NO_FREE = 2'd1,
        ST_NO_RUN  = 2'd2,
        ST_NO_WAIT = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_CREATE,
        S_SCHED,
        S_FEED,
        S_TICK,
        S_RESP
    } t_state;

    typedef struct packed {
        t_status           status;
        logic [ID_W-1:0]   thread_id;
        logic [CHAR_W-1:0] delivered_char;
        logic              running_valid;
        logic [ID_W-1:0]   running_id;
        logic [CNT_W-1:0]  ready_count;
        logic [CNT_W-1:0]  sleeping_count;
        logic [CNT_W-1:0]  waiting_count;
        logic [CNT_W-1:0]  free_count;
    } t_rsp;

endpackage

### design/tqs_if.sv
// Handshake channels of the thread queue scheduler: request in, result out.
// Depends on tqs_pkg for the field widths.
interface tqs_req_if import tqs_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [REQ_W-1:0]   req_type;
    logic [TICKS_W-1:0] sleep_ticks;
    logic [CHAR_W-1:0]  char_value;

    modport source (output valid, req_type, sleep_ticks, char_value, input ready);
    modport sink   (input valid, req_type, sleep_ticks, char_value, output ready);
endinterface

interface tqs_rsp_if import tqs_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [STAT_W-1:0] status;
    logic [ID_W-1:0]   thread_id;
    logic [CHAR_W-1:0] delivered_char;
    logic              running_valid;
    logic [ID_W-1:0]   running_id;
    logic [CNT_W-1:0]  ready_count;
    logic [CNT_W-1:0]  sleeping_count;
    logic [CNT_W-1:0]  waiting_count;
    logic [CNT_W-1:0]  free_count;

    modport source (output valid, status, thread_id, delivered_char, running_valid,
                    running_id, ready_count, sleeping_count, waiting_count, free_count,
                    input ready);
    modport sink   (input valid, status, thread_id, delivered_char, running_valid,
                    running_id, ready_count, sleeping_count, waiting_count, free_count,
                    output ready);
endinterface

### design/thread_queue_scheduler.sv
// Thread queue scheduler: free stack, ready deque, wait FIFO, sleep counters, running slot.
// Sleep, wait, kill and failed requests pass from the execute state to the result state;
// create, schedule and feed pass through a state of their own between the two, and tick walks the sleep
// counter memory one slot per cycle before the result. One item at a time; the next is taken
// only after its result is loaded, and a result that has not been taken holds off the load.
// Synchronous reset frees every slot at once.
module thread_queue_scheduler import tqs_pkg::*; #(
    parameter int unsigned THREAD_COUNT = THREAD_COUNT_DEF,
    parameter int unsigned TICK_WIDTH   = TICK_WIDTH_DEF
) (
    input logic   i_clk,
    input logic   i_rst_n,
    tqs_req_if.sink   i_req,
    tqs_rsp_if.source o_rsp
);

    localparam int unsigned N  = THREAD_COUNT;
    localparam int unsigned SW = $clog2(N);
    localparam int unsigned CW = $clog2(N + 1);
    localparam int unsigned TW = TICK_WIDTH;

    // State registers.
    t_state             r_state, n_state;
    logic [REQ_W-1:0]   r_req, n_req;
    logic [TW-1:0]      r_ticks, n_ticks;
    logic [CHAR_W-1:0]  r_char, n_char;
    logic [CW-1:0]      r_idx, n_idx;
    t_status            r_status, n_status;
    logic [SW-1:0]      r_tid, n_tid;
    logic [CHAR_W-1:0]  r_dchar, n_dchar;
    logic [SW-1:0]      r_rd_head, n_rd_head;
    logic [CW-1:0]      r_rd_cnt, n_rd_cnt;
    logic [CW-1:0]      r_fs_cnt, n_fs_cnt;
    logic [N-1:0]       r_fs_wr, n_fs_wr;
    logic [SW-1:0]      r_wf_head, n_wf_head;
    logic [CW-1:0]      r_wf_cnt, n_wf_cnt;
    logic [N-1:0]       r_sl_flag, n_sl_flag;
    logic [CW-1:0]      r_sl_cnt, n_sl_cnt;
    logic [SW-1:0]      r_run_slot, n_run_slot;
    logic               r_run_flag, n_run_flag;
    logic               r_out_valid, n_out_valid;
    t_rsp               r_rsp, n_rsp;

    // Memory ports.
    logic          rq_we, fq_we, wq_we, sl_we;
    logic [SW-1:0] rq_waddr, fq_waddr, wq_waddr, sl_waddr;
    logic [SW-1:0] rq_wdata, fq_wdata, wq_wdata;
    logic [TW-1:0] sl_wdata;
    logic [SW-1:0] rq_raddr, fq_raddr, wq_raddr, sl_raddr;
    logic [SW-1:0] rq_rdata, fq_rdata, wq_rdata;
    logic [TW-1:0] sl_rdata;

    logic          in_acc;
    logic          out_free;
    logic [SW-1:0] free_top;
    logic [SW-1:0] rd_tail;
    logic [SW-1:0] rd_head_dec;
    logic [SW-1:0] tick_slot;
    logic [TW-1:0] sl_dec;

    function automatic logic [SW-1:0] wrap_sum(input logic [SW-1:0] a, input logic [CW-1:0] b);
        logic [CW:0] s;
        s = (CW+1)'(a) + (CW+1)'(b);
        if (s >= (CW+1)'(N)) begin
            s = s - (CW+1)'(N);
        end
        return s[SW-1:0];
    endfunction

    function automatic logic [SW-1:0] wrap_inc(input logic [SW-1:0] a);
        return (a == SW'(N - 1)) ? '0 : a + SW'(1);
    endfunction

    tqs_ram #(.DEPTH(N), .WIDTH(SW)) u_ready_mem (
        .i_clk(i_clk), .i_we(rq_we), .i_waddr(rq_waddr), .i_wdata(rq_wdata),
        .i_raddr(rq_raddr), .o_rdata(rq_rdata)
    );

    tqs_ram #(.DEPTH(N), .WIDTH(SW)) u_free_mem (
        .i_clk(i_clk), .i_we(fq_we), .i_waddr(fq_waddr), .i_wdata(fq_wdata),
        .i_raddr(fq_raddr), .o_rdata(fq_rdata)
    );

    tqs_ram #(.DEPTH(N), .WIDTH(SW)) u_wait_mem (
        .i_clk(i_clk), .i_we(wq_we), .i_waddr(wq_waddr), .i_wdata(wq_wdata),
        .i_raddr(wq_raddr), .o_rdata(wq_rdata)
    );

    tqs_ram #(.DEPTH(N), .WIDTH(TW)) u_sleep_mem (
        .i_clk(i_clk), .i_we(sl_we), .i_waddr(sl_waddr), .i_wdata(sl_wdata),
        .i_raddr(sl_raddr), .o_rdata(sl_rdata)
    );

    assign i_req.ready = (r_state == S_IDLE);
    assign in_acc      = i_req.valid && (r_state == S_IDLE);
    assign out_free    = !r_out_valid || o_rsp.ready;

    // Reads are issued continuously from the queue pointers; the registered data is used in
    // the cycle after, when the pointers have not moved yet.
    assign rq_raddr = r_rd_head;
    assign wq_raddr = r_wf_head;
    assign fq_raddr = SW'(r_fs_cnt - CW'(1));
    assign sl_raddr = SW'(r_idx);

    // A free-stack entry never written since reset holds its initial slot number.
    assign free_top    = r_fs_wr[fq_raddr] ? fq_rdata : SW'(N - 1) - fq_raddr;
    assign rd_tail     = wrap_sum(r_rd_head, r_rd_cnt);
    assign rd_head_dec = (r_rd_head == '0) ? SW'(N - 1) : r_rd_head - SW'(1);
    assign tick_slot   = SW'(r_idx - CW'(1));
    assign sl_dec      = (sl_rdata != '0) ? sl_rdata - TW'(1) : '0;

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                case (r_req)
                    REQ_CREATE: n_state = (r_fs_cnt != '0) ? S_CREATE : S_RESP;
                    REQ_SCHED:  n_state = (r_rd_cnt != '0) ? S_SCHED : S_RESP;
                    REQ_FEED:   n_state = (r_wf_cnt != '0) ? S_FEED : S_RESP;
                    REQ_TICK:   n_state = S_TICK;
                    default:    n_state = S_RESP;
                endcase
            end
            S_CREATE, S_SCHED, S_FEED: begin
                n_state = S_RESP;
            end
            S_TICK: begin
                if (r_idx == CW'(N)) begin
                    n_state = S_RESP;
                end
            end
            S_RESP: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Datapath and memory controls.
    always_comb begin
        n_req       = r_req;
        n_ticks     = r_ticks;
        n_char      = r_char;
        n_idx       = r_idx;
        n_status    = r_status;
        n_tid       = r_tid;
        n_dchar     = r_dchar;
        n_rd_head   = r_rd_head;
        n_rd_cnt    = r_rd_cnt;
        n_fs_cnt    = r_fs_cnt;
        n_fs_wr     = r_fs_wr;
        n_wf_head   = r_wf_head;
        n_wf_cnt    = r_wf_cnt;
        n_sl_flag   = r_sl_flag;
        n_sl_cnt    = r_sl_cnt;
        n_run_slot  = r_run_slot;
        n_run_flag  = r_run_flag;
        n_out_valid = r_out_valid && !o_rsp.ready;
        n_rsp       = r_rsp;
        rq_we = 1'b0;  rq_waddr = '0;  rq_wdata = '0;
        fq_we = 1'b0;  fq_waddr = '0;  fq_wdata = '0;
        wq_we = 1'b0;  wq_waddr = '0;  wq_wdata = '0;
        sl_we = 1'b0;  sl_waddr = '0;  sl_wdata = '0;

        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_req    = i_req.req_type;
                    n_ticks  = TW'(i_req.sleep_ticks);
                    n_char   = i_req.char_value;
                    n_idx    = '0;
                    n_status = ST_OK;
                    n_tid    = '0;
                    n_dchar  = '0;
                end
            end
            S_EXEC: begin
                case (r_req)
                    REQ_CREATE: begin
                        if (r_fs_cnt == '0) begin
                            n_status = ST_NO_FREE;
                        end
                    end
                    REQ_SLEEP: begin
                        if (!r_run_flag) begin
                            n_status = ST_NO_RUN;
                        end else begin
                            sl_we                 = 1'b1;
                            sl_waddr              = r_run_slot;
                            sl_wdata              = r_ticks;
                            n_sl_flag[r_run_slot] = 1'b1;
                            n_sl_cnt              = r_sl_cnt + CW'(1);
                            n_run_flag            = 1'b0;
                            n_run_slot            = '0;
                        end
                    end
                    REQ_WAIT: begin
                        if (!r_run_flag) begin
                            n_status = ST_NO_RUN;
                        end else begin
                            wq_we      = 1'b1;
                            wq_waddr   = wrap_sum(r_wf_head, r_wf_cnt);
                            wq_wdata   = r_run_slot;
                            n_wf_cnt   = r_wf_cnt + CW'(1);
                            n_run_flag = 1'b0;
                            n_run_slot = '0;
                        end
                    end
                    REQ_KILL: begin
                        if (!r_run_flag) begin
                            n_status = ST_NO_RUN;
                        end else begin
                            fq_we             = 1'b1;
                            fq_waddr          = SW'(r_fs_cnt);
                            fq_wdata          = r_run_slot;
                            n_fs_wr[fq_waddr] = 1'b1;
                            n_fs_cnt          = r_fs_cnt + CW'(1);
                            n_run_flag        = 1'b0;
                            n_run_slot        = '0;
                        end
                    end
                    REQ_FEED: begin
                        if (r_wf_cnt == '0) begin
                            n_status = ST_NO_WAIT;
                        end
                    end
                    REQ_TICK: begin
                        // Slot 0 is being read now; the walk starts with the next index.
                        n_idx = CW'(1);
                    end
                    default: begin
                    end
                endcase
            end
            S_CREATE: begin
                rq_we    = 1'b1;
                rq_waddr = rd_tail;
                rq_wdata = free_top;
                n_rd_cnt = r_rd_cnt + CW'(1);
                n_fs_cnt = r_fs_cnt - CW'(1);
                n_tid    = free_top;
            end
            S_SCHED: begin
                n_rd_head = wrap_inc(r_rd_head);
                if (r_run_flag) begin
                    // The old tail position is the new tail once the head has moved on.
                    rq_we    = 1'b1;
                    rq_waddr = rd_tail;
                    rq_wdata = r_run_slot;
                end else begin
                    n_rd_cnt = r_rd_cnt - CW'(1);
                end
                n_run_slot = rq_rdata;
                n_run_flag = 1'b1;
            end
            S_FEED: begin
                n_wf_head = wrap_inc(r_wf_head);
                n_wf_cnt  = r_wf_cnt - CW'(1);
                rq_we     = 1'b1;
                rq_waddr  = rd_head_dec;
                rq_wdata  = wq_rdata;
                n_rd_head = rd_head_dec;
                n_rd_cnt  = r_rd_cnt + CW'(1);
                n_tid     = wq_rdata;
                n_dchar   = r_char;
            end
            S_TICK: begin
                // The counter of the previous index arrives while the next one is read.
                if (r_sl_flag[tick_slot]) begin
                    sl_we    = 1'b1;
                    sl_waddr = tick_slot;
                    sl_wdata = sl_dec;
                    if (sl_dec == '0) begin
                        n_sl_flag[tick_slot] = 1'b0;
                        n_sl_cnt             = r_sl_cnt - CW'(1);
                        rq_we                = 1'b1;
                        rq_waddr             = rd_head_dec;
                        rq_wdata             = tick_slot;
                        n_rd_head            = rd_head_dec;
                        n_rd_cnt             = r_rd_cnt + CW'(1);
                    end
                end
                n_idx = r_idx + CW'(1);
            end
            S_RESP: begin
                if (out_free) begin
                    n_out_valid          = 1'b1;
                    n_rsp.status         = r_status;
                    n_rsp.thread_id      = ID_W'(r_tid);
                    n_rsp.delivered_char = r_dchar;
                    n_rsp.running_valid  = r_run_flag;
                    n_rsp.running_id     = r_run_flag ? ID_W'(r_run_slot) : '0;
                    n_rsp.ready_count    = CNT_W'(r_rd_cnt);
                    n_rsp.sleeping_count = CNT_W'(r_sl_cnt);
                    n_rsp.waiting_count  = CNT_W'(r_wf_cnt);
                    n_rsp.free_count     = CNT_W'(r_fs_cnt);
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_rd_head   <= '0;
            r_rd_cnt    <= '0;
            r_fs_cnt    <= CW'(N);
            r_fs_wr     <= '0;
            r_wf_head   <= '0;
            r_wf_cnt    <= '0;
            r_sl_flag   <= '0;
            r_sl_cnt    <= '0;
            r_run_slot  <= '0;
            r_run_flag  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_rd_head   <= n_rd_head;
            r_rd_cnt    <= n_rd_cnt;
            r_fs_cnt    <= n_fs_cnt;
            r_fs_wr     <= n_fs_wr;
            r_wf_head   <= n_wf_head;
            r_wf_cnt    <= n_wf_cnt;
            r_sl_flag   <= n_sl_flag;
            r_sl_cnt    <= n_sl_cnt;
            r_run_slot  <= n_run_slot;
            r_run_flag  <= n_run_flag;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_req    <= n_req;
        r_ticks  <= n_ticks;
        r_char   <= n_char;
        r_idx    <= n_idx;
        r_status <= n_status;
        r_tid    <= n_tid;
        r_dchar  <= n_dchar;
        r_rsp    <= n_rsp;
    end

    assign o_rsp.valid          = r_out_valid;
    assign o_rsp.status         = r_rsp.status;
    assign o_rsp.thread_id      = r_rsp.thread_id;
    assign o_rsp.delivered_char = r_rsp.delivered_char;
    assign o_rsp.running_valid  = r_rsp.running_valid;
    assign o_rsp.running_id     = r_rsp.running_id;
    assign o_rsp.ready_count    = r_rsp.ready_count;
    assign o_rsp.sleeping_count = r_rsp.sleeping_count;
    assign o_rsp.waiting_count  = r_rsp.waiting_count;
    assign o_rsp.free_count     = r_rsp.free_count;

endmodule

### design/tqs_ram.sv
// Simple dual-port memory with one write port and one registered read port.
// Used for the slot queues and the sleep counters. No dependencies.
module tqs_ram #(
    parameter int unsigned DEPTH = 8,
    parameter int unsigned WIDTH = 3,
    parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### sim/tb_top.sv
// Self-checking testbench for the thread queue scheduler. A behavioral copy of the
// scheduler predicts each result, and every result is compared field by field.
// Depends on tqs_pkg, tqs_if and thread_queue_scheduler.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import tqs_pkg::*;

    typedef logic [ID_W-1:0] t_slot;

    localparam logic [REQ_W-1:0] REQ_UNUSED = 3'd7;
    localparam int unsigned NSLOT        = THREAD_COUNT_DEF;
    localparam int unsigned IDLE_LIMIT   = 2000;
    localparam int unsigned MAX_SHOWN    = 10;
    localparam int unsigned RANDOM_ITEMS = 660;

    logic i_clk = 1'b0;
    logic i_rst_n;

    tqs_req_if req_ch ();
    tqs_rsp_if rsp_ch ();

    thread_queue_scheduler DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch)
    );

    // Scheduler copy. The back of free_q is the top of the free stack.
    t_slot                     ready_q[$];
    t_slot                     free_q[$];
    t_slot                     wait_q[$];
    logic [TICK_WIDTH_DEF-1:0] ticks_left [NSLOT];
    bit                        asleep [NSLOT];
    t_slot                     run_slot;
    bit                        run_flag;

    t_rsp        pending_rsp_q[$];
    int unsigned mismatch_cnt = 0;
    int unsigned idle_cycles = 0;
    int unsigned rsp_hold = 0;
    bit          calm = 1'b0;

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    function automatic int unsigned draw_idle();
        if (calm) begin
            return 0;
        end
        return $urandom_range(0, 5);
    endfunction

    task automatic reset_model();
        int i;
        ready_q.delete();
        wait_q.delete();
        free_q.delete();
        for (i = NSLOT - 1; i >= 0; i--) begin
            free_q.push_back(t_slot'(i));
        end
        for (i = 0; i < NSLOT; i++) begin
            ticks_left[i] = '0;
            asleep[i] = 1'b0;
        end
        run_slot = '0;
        run_flag = 1'b0;
    endtask

    function automatic t_rsp predict_rsp(logic [REQ_W-1:0] code, logic [TICKS_W-1:0] ticks,
                                         logic [CHAR_W-1:0] ch);
        t_rsp  r;
        t_slot s;
        int    i;
        int    sleepers;
        r = '0;
        r.status = ST_OK;
        case (code)
            REQ_CREATE: begin
                if (free_q.size() == 0) begin
                    r.status = ST_NO_FREE;
                end else begin
                    s = free_q.pop_back();
                    if (ready_q.size() < NSLOT) ready_q.push_back(s);
                    r.thread_id = s;
                end
            end
            REQ_SLEEP, REQ_WAIT, REQ_KILL: begin
                if (!run_flag) begin
                    r.status = ST_NO_RUN;
                end else begin
                    s = run_slot;
                    run_flag = 1'b0;
                    run_slot = '0;
                    if (code == REQ_SLEEP) begin
                        ticks_left[s] = ticks[TICK_WIDTH_DEF-1:0];
                        asleep[s] = 1'b1;
                    end else if (code == REQ_WAIT) begin
                        if (wait_q.size() < NSLOT) wait_q.push_back(s);
                    end else if (free_q.size() < NSLOT) begin
                        free_q.push_back(s);
                    end
                end
            end
            REQ_SCHED: begin
                if (ready_q.size() != 0) begin
                    s = ready_q.pop_front();
                    if (run_flag && ready_q.size() < NSLOT) ready_q.push_back(run_slot);
                    run_slot = s;
                    run_flag = 1'b1;
                end
            end
            REQ_TICK: begin
                // Expired slots go to the head in increasing order, so the highest leads.
                for (i = 0; i < NSLOT; i++) begin
                    if (asleep[i]) begin
                        if (ticks_left[i] != 0) ticks_left[i]--;
                        if (ticks_left[i] == 0) begin
                            asleep[i] = 1'b0;
                            if (ready_q.size() < NSLOT) ready_q.push_front(t_slot'(i));
                        end
                    end
                end
            end
            REQ_FEED: begin
                if (wait_q.size() == 0) begin
                    r.status = ST_NO_WAIT;
                end else begin
                    s = wait_q.pop_front();
                    if (ready_q.size() < NSLOT) ready_q.push_front(s);
                    r.thread_id = s;
                    r.delivered_char = ch;
                end
            end
            default: ;
        endcase
        sleepers = 0;
        for (i = 0; i < NSLOT; i++) begin
            if (asleep[i]) sleepers++;
        end
        r.running_valid  = run_flag;
        r.running_id     = run_flag ? run_slot : '0;
        r.ready_count    = CNT_W'(ready_q.size());
        r.sleeping_count = CNT_W'(sleepers);
        r.waiting_count  = CNT_W'(wait_q.size());
        r.free_count     = CNT_W'(free_q.size());
        return r;
    endfunction

    // Entered just after a falling edge; returns just after the falling edge that
    // follows the acceptance of the item.
    task automatic issue_req(logic [REQ_W-1:0] code, logic [TICKS_W-1:0] ticks,
                             logic [CHAR_W-1:0] ch);
        int unsigned gap;
        gap = draw_idle();
        if (gap != 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        req_ch.valid       <= 1'b1;
        req_ch.req_type    <= code;
        req_ch.sleep_ticks <= ticks;
        req_ch.char_value  <= ch;
        do @(posedge i_clk); while (!req_ch.ready);
        pending_rsp_q.push_back(predict_rsp(code, ticks, ch));
        @(negedge i_clk);
    endtask

    task automatic wait_all_results();
        req_ch.valid <= 1'b0;
        while (pending_rsp_q.size() != 0) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic check_field(string name, int unsigned want, int unsigned got);
        if (want != got) begin
            mismatch_cnt++;
            if (mismatch_cnt <= MAX_SHOWN) begin
                $display("ERROR: %s expected %0d, got %0d at %0t", name, want, got, $time);
            end
        end
    endtask

    always @(posedge i_clk) begin
        t_rsp want;
        if (i_rst_n && rsp_ch.valid && rsp_ch.ready) begin
            rsp_hold = draw_idle();
            if (pending_rsp_q.size() == 0) begin
                mismatch_cnt++;
                if (mismatch_cnt <= MAX_SHOWN) begin
                    $display("ERROR: result with no request outstanding at %0t", $time);
                end
            end else begin
                want = pending_rsp_q.pop_front();
                check_field("status", want.status, rsp_ch.status);
                check_field("thread_id", want.thread_id, rsp_ch.thread_id);
                check_field("delivered_char", want.delivered_char, rsp_ch.delivered_char);
                check_field("running_valid", want.running_valid, rsp_ch.running_valid);
                check_field("running_id", want.running_id, rsp_ch.running_id);
                check_field("ready_count", want.ready_count, rsp_ch.ready_count);
                check_field("sleeping_count", want.sleeping_count, rsp_ch.sleeping_count);
                check_field("waiting_count", want.waiting_count, rsp_ch.waiting_count);
                check_field("free_count", want.free_count, rsp_ch.free_count);
            end
        end
    end

    always @(negedge i_clk) begin
        if (rsp_hold != 0) begin
            rsp_ch.ready <= 1'b0;
            rsp_hold--;
        end else begin
            rsp_ch.ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("tb: failure");
                $finish;
            end
        end
    end

    // Requests that need a running thread fail while idle, as do feed with no waiting
    // thread; schedule with nothing ready and an unused request code leave everything as it is.
    task automatic test_idle_errors();
        issue_req(REQ_SLEEP, 16'h0003, 8'h00);
        issue_req(REQ_WAIT, 16'h0000, 8'h00);
        issue_req(REQ_KILL, 16'h0000, 8'h00);
        issue_req(REQ_SCHED, 16'h0000, 8'h00);
        issue_req(REQ_FEED, 16'h0000, 8'hFF);
        issue_req(REQ_UNUSED, 16'hFFFF, 8'hFF);
    endtask

    // Creating one more thread than there are slots reports no free slot.
    task automatic test_create_exhaust();
        repeat (NSLOT + 1) issue_req(REQ_CREATE, 16'h0000, 8'h00);
    endtask

    // A zero-tick sleep wakes on the next tick, two slots expire on one tick,
    // and a fed character wakes the waiting thread to the ready head.
    task automatic test_sleep_wait_wake();
        issue_req(REQ_SCHED, 16'h0000, 8'h00);
        issue_req(REQ_SLEEP, 16'h0000, 8'h00);
        issue_req(REQ_SCHED, 16'h0000, 8'h00);
        issue_req(REQ_SLEEP, 16'hFFFF, 8'h00);
        issue_req(REQ_SCHED, 16'h0000, 8'h00);
        issue_req(REQ_WAIT, 16'h0000, 8'h00);
        issue_req(REQ_SCHED, 16'h0000, 8'h00);
        issue_req(REQ_SLEEP, 16'h0000, 8'h00);
        issue_req(REQ_TICK, 16'h0000, 8'h00);
        issue_req(REQ_FEED, 16'h0000, 8'h00);
    endtask

    // Round-robin rotation, then a killed slot is the next one created.
    task automatic test_kill_rotate();
        issue_req(REQ_SCHED, 16'h0000, 8'h00);
        issue_req(REQ_SCHED, 16'h0000, 8'h00);
        issue_req(REQ_KILL, 16'h0000, 8'h00);
        issue_req(REQ_CREATE, 16'h0000, 8'h00);
    endtask

    // Biased toward requests that move threads on, so that every queue fills and drains.
    function automatic logic [REQ_W-1:0] pick_req();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (!run_flag && ready_q.size() != 0 && r < 50) return REQ_SCHED;
        r = $urandom_range(0, 99);
        if (r < 12) return REQ_CREATE;
        if (r < 26) return REQ_SLEEP;
        if (r < 38) return REQ_WAIT;
        if (r < 44) return REQ_KILL;
        if (r < 64) return REQ_SCHED;
        if (r < 86) return REQ_TICK;
        if (r < 98) return REQ_FEED;
        return REQ_UNUSED;
    endfunction

    task automatic test_random_traffic(int unsigned count);
        logic [REQ_W-1:0]   code;
        logic [TICKS_W-1:0] ticks;
        logic [CHAR_W-1:0]  ch;
        int unsigned        n;
        for (n = 0; n < count; n++) begin
            if (n % 110 == 0) calm = ($urandom_range(0, 3) == 0);
            code  = pick_req();
            ticks = TICKS_W'($urandom_range(0, 16'hFFFF));
            if (code == REQ_SLEEP) begin
                ticks = ($urandom_range(0, 19) == 0) ? TICKS_W'($urandom_range(8, 48))
                                                     : TICKS_W'($urandom_range(0, 6));
            end
            ch = CHAR_W'($urandom_range(0, 255));
            issue_req(code, ticks, ch);
        end
        calm = 1'b0;
    endtask

    task automatic test_sender_pause();
        wait_all_results();
        issue_req(REQ_TICK, 16'h0000, 8'h00);
        issue_req(REQ_SCHED, 16'h0000, 8'h00);
    endtask

    initial begin
        req_ch.valid       = 1'b0;
        req_ch.req_type    = '0;
        req_ch.sleep_ticks = '0;
        req_ch.char_value  = '0;
        rsp_ch.ready       = 1'b0;
        i_rst_n            = 1'b0;
        reset_model();
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_idle_errors();
        test_create_exhaust();
        test_sleep_wait_wake();
        test_kill_rotate();
        test_random_traffic(RANDOM_ITEMS);
        test_sender_pause();
        test_random_traffic(RANDOM_ITEMS);

        wait_all_results();
        repeat (2 * NSLOT) @(posedge i_clk);
        if (mismatch_cnt == 0 && pending_rsp_q.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
